// ----- src/crs_pkg.sv -----
package crs_pkg;

    // Coordinate and count widths of the ports.
    localparam int CW         = 32;
    localparam int CNTW       = 7;
    localparam int MAX_POINTS = 64;

    // Segment divisions n = count + 1 fit in NW bits.
    localparam int NW = $clog2(MAX_POINTS + 2);
    // Polynomial coefficients need four bits of headroom over a coordinate.
    localparam int KW = CW + 4;
    // Weights i*n*n, i*i*n, i*i*i and n*n*n all stay at or below (MAX_POINTS+1)^3.
    localparam int WW = $clog2((MAX_POINTS + 1) * (MAX_POINTS + 1) * (MAX_POINTS + 1) + 1);
    // Divisor 2*n^3.
    localparam int DW = WW + 1;
    // One coefficient times one weight.
    localparam int PW = KW + WW;
    // Sum of three products plus the rounding offset.
    localparam int SW = PW + 2;

    // One queued segment, already reduced to polynomial form.
    typedef struct packed {
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [KW-1:0] a_x;
        logic signed [KW-1:0] b_x;
        logic signed [KW-1:0] c_x;
        logic signed [KW-1:0] a_y;
        logic signed [KW-1:0] b_y;
        logic signed [KW-1:0] c_y;
        logic [NW-1:0]        count;
    } t_seg;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- src/catmull_rom_segment_subdivider_core.sv -----
// Uniform Catmull-Rom segment subdivider. Each input word is one segment
// (control points P0..P3 in signed Q16.16 and a point count, saturated to 64)
// and yields count output words: the curve points at t = i/(count+1), rounded
// to nearest with ties up, clamped to the coordinate range, the final one
// marked by o_last_point; a count of zero yields nothing. A front register
// reduces each segment to polynomial coefficients and parks it in a two-entry
// queue, so up to three segments can be accepted while points are still
// being produced. Each point passes through weight setup, then the one shared
// coefficient multiplier, then the bit-serial x and y dividers that run side
// by side; each segment first adds its own setup.
module catmull_rom_segment_subdivider_core
    import crs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_p0_x,
    input  logic signed [CW-1:0] i_p0_y,
    input  logic signed [CW-1:0] i_p1_x,
    input  logic signed [CW-1:0] i_p1_y,
    input  logic signed [CW-1:0] i_p2_x,
    input  logic signed [CW-1:0] i_p2_y,
    input  logic signed [CW-1:0] i_p3_x,
    input  logic signed [CW-1:0] i_p3_y,
    input  logic [CNTW-1:0]      i_point_count,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [CW-1:0] o_out_x,
    output logic signed [CW-1:0] o_out_y,
    output logic                 o_last_point
);

    t_qstat qstat;
    t_seg   push_seg;
    t_seg   head_seg;
    logic   push;
    logic   pop;

    crs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_p0_x        (i_p0_x),
        .i_p0_y        (i_p0_y),
        .i_p1_x        (i_p1_x),
        .i_p1_y        (i_p1_y),
        .i_p2_x        (i_p2_x),
        .i_p2_y        (i_p2_y),
        .i_p3_x        (i_p3_x),
        .i_p3_y        (i_p3_y),
        .i_point_count (i_point_count),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_seg         (push_seg)
    );

    crs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_seg),
        .i_pop   (pop),
        .o_data  (head_seg),
        .o_stat  (qstat)
    );

    crs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (head_seg),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_last_point (o_last_point)
    );

endmodule

// ----- src/crs_front.sv -----
module crs_front
    import crs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [CW-1:0]   i_p0_x,
    input  logic signed [CW-1:0]   i_p0_y,
    input  logic signed [CW-1:0]   i_p1_x,
    input  logic signed [CW-1:0]   i_p1_y,
    input  logic signed [CW-1:0]   i_p2_x,
    input  logic signed [CW-1:0]   i_p2_y,
    input  logic signed [CW-1:0]   i_p3_x,
    input  logic signed [CW-1:0]   i_p3_y,
    input  logic [CNTW-1:0]        i_point_count,
    input  t_qstat                 i_qstat,
    output logic                   o_push,
    output t_seg                   o_seg
);

    logic                 r_valid;
    logic signed [CW-1:0] r_p0_x, r_p0_y, r_p1_x, r_p1_y;
    logic signed [CW-1:0] r_p2_x, r_p2_y, r_p3_x, r_p3_y;
    logic [NW-1:0]        r_count;
    logic                 fire;
    logic                 load;
    logic [NW-1:0]        clamped;

    // A word leaves the input register once the queue has room, or at once
    // when it asks for no points.
    assign fire    = r_valid & (~i_qstat.full | (r_count == '0));
    assign o_stall = r_valid & ~fire;
    assign load    = i_valid & ~o_stall;
    assign o_push  = fire & (r_count != '0);

    // Counts above the maximum saturate.
    always_comb begin
        if (i_point_count > CNTW'(MAX_POINTS)) begin
            clamped = NW'(MAX_POINTS);
        end else begin
            clamped = NW'(i_point_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p0_x  <= i_p0_x;
            r_p0_y  <= i_p0_y;
            r_p1_x  <= i_p1_x;
            r_p1_y  <= i_p1_y;
            r_p2_x  <= i_p2_x;
            r_p2_y  <= i_p2_y;
            r_p3_x  <= i_p3_x;
            r_p3_y  <= i_p3_y;
            r_count <= clamped;
        end
    end

    // Polynomial coefficients of the uniform curve, times two.
    function automatic logic signed [KW-1:0] ext(input logic signed [CW-1:0] v);
        ext = {{(KW-CW){v[CW-1]}}, v};
    endfunction

    always_comb begin
        o_seg.p1_x  = r_p1_x;
        o_seg.p1_y  = r_p1_y;
        o_seg.count = r_count;
        o_seg.a_x   = ext(r_p2_x) - ext(r_p0_x);
        o_seg.b_x   = (ext(r_p0_x) <<< 1) - (ext(r_p1_x) <<< 2) - ext(r_p1_x)
                    + (ext(r_p2_x) <<< 2) - ext(r_p3_x);
        o_seg.c_x   = (ext(r_p1_x) <<< 1) + ext(r_p1_x) - ext(r_p0_x)
                    - (ext(r_p2_x) <<< 1) - ext(r_p2_x) + ext(r_p3_x);
        o_seg.a_y   = ext(r_p2_y) - ext(r_p0_y);
        o_seg.b_y   = (ext(r_p0_y) <<< 1) - (ext(r_p1_y) <<< 2) - ext(r_p1_y)
                    + (ext(r_p2_y) <<< 2) - ext(r_p3_y);
        o_seg.c_y   = (ext(r_p1_y) <<< 1) + ext(r_p1_y) - ext(r_p0_y)
                    - (ext(r_p2_y) <<< 1) - ext(r_p2_y) + ext(r_p3_y);
    end

endmodule

// ----- src/crs_queue.sv -----
module crs_queue
    import crs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_seg   i_data,
    input  logic   i_pop,
    output t_seg   o_data,
    output t_qstat o_stat
);

    t_seg       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Two-entry queue between front and back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/crs_div.sv -----
module crs_div
    import crs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [SW-1:0] i_num,
    input  logic [DW-1:0]       i_den,
    output logic                o_done,
    output logic signed [SW:0]  o_quo
);

    localparam int CNT_W = $clog2(SW + 1);

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [SW-1:0]     r_quo;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic signed [SW:0] r_res;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              ge;
    logic [SW:0]       adj;

    assign o_done = r_done;
    assign o_quo  = r_res;

    // One restoring step per cycle on the magnitude.
    assign trial = {r_rem, r_quo[SW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign adj   = {1'b0, r_quo} + {{SW{1'b0}}, (r_rem != '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[SW-1];
            r_quo <= i_num[SW-1] ? SW'(-i_num) : SW'(i_num);
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(SW);
        end else if (r_busy) begin
            r_quo <= {r_quo[SW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
        // Floor for a negative numerator: round the magnitude up.
        if (r_fin) begin
            r_res <= r_neg ? $signed(-adj) : $signed({1'b0, r_quo});
        end
    end

endmodule

// ----- src/crs_back.sv -----
module crs_back
    import crs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_seg                 i_seg,
    input  t_qstat               i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [CW-1:0] o_out_x,
    output logic signed [CW-1:0] o_out_y,
    output logic                 o_last_point
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_N2   = 3'd1;
    localparam logic [2:0] S_N3   = 3'd2;
    localparam logic [2:0] S_W1   = 3'd3;
    localparam logic [2:0] S_W2   = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]           r_state;
    logic [2:0]           r_k;
    t_seg                 r_seg;
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_i;
    logic [2*NW-1:0]      r_n2;
    logic [2*NW-1:0]      r_i2;
    logic [WW-1:0]        r_n3;
    logic [WW-1:0]        r_w1;
    logic [WW-1:0]        r_w2;
    logic [WW-1:0]        r_w3;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_acc_x;
    logic signed [SW-1:0] r_acc_y;
    logic signed [CW-1:0] r_out_x;
    logic signed [CW-1:0] r_out_y;
    logic                 r_last;
    logic signed [KW-1:0] m_coef;
    logic [WW-1:0]        m_w;
    logic signed [SW-1:0] prod_ext;
    logic                 div_start;
    logic                 done_x;
    logic                 done_y;
    logic signed [SW:0]   quo_x;
    logic signed [SW:0]   quo_y;
    logic [DW-1:0]        den;
    logic                 take;

    assign o_pop        = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_valid      = (r_state == S_OUT);
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_last_point = r_last;
    assign take         = o_valid && !i_stall;
    assign div_start    = (r_state == S_MUL) && (r_k == 3'd7);
    assign den          = {r_n3, 1'b0};
    assign prod_ext     = {{(SW-PW){r_prod[PW-1]}}, r_prod};

    // Shared multiplier operand select: three products for x, then three for y.
    always_comb begin
        unique case (r_k)
            3'd0:    begin m_coef = r_seg.a_x; m_w = r_w1; end
            3'd1:    begin m_coef = r_seg.b_x; m_w = r_w2; end
            3'd2:    begin m_coef = r_seg.c_x; m_w = r_w3; end
            3'd3:    begin m_coef = r_seg.a_y; m_w = r_w1; end
            3'd4:    begin m_coef = r_seg.b_y; m_w = r_w2; end
            default: begin m_coef = r_seg.c_y; m_w = r_w3; end
        endcase
    end

    // Add p1 to the rounded offset and clamp to the coordinate range.
    function automatic logic signed [CW-1:0] finish(input logic signed [CW-1:0] p,
                                                    input logic signed [SW:0] q);
        logic signed [SW+1:0] s;
        s = $signed({{(SW+2-CW){p[CW-1]}}, p}) + $signed({q[SW], q});
        if (s[SW+1:CW-1] == '0 || s[SW+1:CW-1] == '1) begin
            finish = s[CW-1:0];
        end else begin
            finish = s[SW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    crs_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc_x),
        .i_den   (den),
        .o_done  (done_x),
        .o_quo   (quo_x)
    );

    crs_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc_y),
        .i_den   (den),
        .o_done  (done_y),
        .o_quo   (quo_y)
    );

    // Point sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_pop) r_state <= S_N2;
                S_N2:   r_state <= S_N3;
                S_N3:   r_state <= S_W1;
                S_W1:   r_state <= S_W2;
                S_W2:   r_state <= S_MUL;
                S_MUL:  if (r_k == 3'd7) r_state <= S_DIV;
                S_DIV:  if (done_x && done_y) r_state <= S_OUT;
                S_OUT: begin
                    if (take) begin
                        r_state <= r_last ? S_IDLE : S_W1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seg <= i_seg;
            r_n   <= i_seg.count + NW'(1);
            r_i   <= NW'(1);
        end
        if (r_state == S_N2) begin
            r_n2 <= (2*NW)'(r_n) * (2*NW)'(r_n);
        end
        if (r_state == S_N3) begin
            r_n3 <= WW'(r_n2) * WW'(r_n);
        end
        if (r_state == S_W1) begin
            r_i2 <= (2*NW)'(r_i) * (2*NW)'(r_i);
            r_w1 <= WW'(r_n2) * WW'(r_i);
        end
        if (r_state == S_W2) begin
            r_w2    <= WW'(r_i2) * WW'(r_n);
            r_w3    <= WW'(r_i2) * WW'(r_i);
            r_k     <= 3'd0;
            r_acc_x <= $signed({{(SW-WW){1'b0}}, r_n3});
            r_acc_y <= $signed({{(SW-WW){1'b0}}, r_n3});
        end
        if (r_state == S_MUL) begin
            r_k <= r_k + 3'd1;
            if (r_k <= 3'd5) begin
                r_prod <= PW'(m_coef) * PW'($signed({1'b0, m_w}));
            end
            if (r_k >= 3'd1 && r_k <= 3'd3) begin
                r_acc_x <= r_acc_x + prod_ext;
            end
            if (r_k >= 3'd4 && r_k <= 3'd6) begin
                r_acc_y <= r_acc_y + prod_ext;
            end
        end
        if (r_state == S_DIV && done_x && done_y) begin
            r_out_x <= finish(r_seg.p1_x, quo_x);
            r_out_y <= finish(r_seg.p1_y, quo_y);
            r_last  <= (r_i == r_seg.count);
        end
        if (take) begin
            r_i <= r_i + NW'(1);
        end
    end

endmodule
